[src/bounded_double_ended_queue_assert.svh]
// Assertion macros used by the deque datapath; they compile away when SYNTH is defined.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`else

`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/bdq_pkg.sv]
// Shared types, codes and constants of the bounded double-ended queue.
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int CAP_W         = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Register index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic rd_front;   // address the front entry for the next read
    logic cap_pop;    // read data holds the popped entry
    logic cap_front;  // read data holds the front entry
    logic load_out;   // read data holds the back entry; fill the output register
  } bdq_ctl_t;

endpackage

[src/bdq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/bdq_ctrl.sv]
// Sequencer of the deque: takes a beat, steps through the reads, hands off the result.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bdq_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_FRONT = 5'b00100,
    S_BACK  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Command decode.
  always_comb begin
    ctl           = '0;
    ctl.accept    = (state == S_IDLE) && in_valid;
    ctl.rd_front  = (state == S_POP);
    ctl.cap_pop   = (state == S_POP);
    ctl.cap_front = (state == S_FRONT);
    ctl.load_out  = ((state == S_BACK) || (state == S_HOLD)) && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_POP;
      S_POP:   state_next = S_FRONT;
      S_FRONT: state_next = S_BACK;
      S_BACK:  state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[src/bdq_dpath.sv]
// Deque datapath: ring pointers, entry count, entry RAM and result registers.
module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bdq_ctl_t                 ctl,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic [CAP_W-1:0]         capacity,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]         occupancy,
  output logic                     is_empty
);

`include "bounded_double_ended_queue_assert.svh"

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0]  front_index, back_index;
  logic [CNT_W-1:0]  entry_count;
  logic [IDX_W-1:0]  front_up, front_dn, back_up, back_dn;
  logic              is_push, full, empty, push_ok, pop_ok;
  logic              pop_ok_q;
  status_t           status_q;
  logic [DATA_W-1:0] popped_q, front_q;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Ring pointer neighbors.
  always_comb begin
    front_up = (front_index == LAST_IDX) ? '0 : front_index + 1'b1;
    front_dn = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
    back_up  = (back_index == LAST_IDX) ? '0 : back_index + 1'b1;
    back_dn  = (back_index == '0) ? LAST_IDX : back_index - 1'b1;
  end

  // Full and empty tests; a capacity above the depth acts as the depth.
  always_comb begin
    is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
    full    = (CMP_W'(entry_count) >= CMP_W'(capacity)) ||
              (entry_count >= CNT_W'(DEPTH));
    empty   = (entry_count == '0);
    push_ok = is_push && !full;
    pop_ok  = !is_push && !empty;
  end

  // RAM addressing: write the pushed value, read the popped, front and back entries in turn.
  always_comb begin
    ram_we    = ctl.accept && push_ok;
    ram_waddr = (cmd == CMD_PUSH_FRONT) ? front_dn : back_index;
    if (ctl.accept) begin
      ram_raddr = (cmd == CMD_POP_FRONT) ? front_index : back_dn;
    end else if (ctl.rd_front) begin
      ram_raddr = front_index;
    end else begin
      ram_raddr = back_dn;
    end
  end

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(push_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Pointers and count move when a beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      entry_count <= '0;
    end else if (ctl.accept) begin
      if (push_ok) begin
        entry_count <= entry_count + 1'b1;
        if (cmd == CMD_PUSH_FRONT) begin
          front_index <= front_dn;
        end else begin
          back_index <= back_up;
        end
      end else if (pop_ok) begin
        entry_count <= entry_count - 1'b1;
        if (cmd == CMD_POP_FRONT) begin
          front_index <= front_up;
        end else begin
          back_index <= back_dn;
        end
      end
    end
  end

  // Per-beat result capture.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      pop_ok_q <= pop_ok;
      if (is_push) begin
        status_q <= full ? STAT_FULL : STAT_DONE;
      end else begin
        status_q <= empty ? STAT_EMPTY : STAT_DONE;
      end
    end
    if (ctl.cap_pop) begin
      popped_q <= pop_ok_q ? ram_rdata : '0;
    end
    if (ctl.cap_front) begin
      front_q <= (entry_count != '0) ? ram_rdata : '0;
    end
  end

  // Output register; the back entry comes straight from the read port.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status       <= status_q;
      popped_value <= $signed(popped_q);
      front_value  <= $signed(front_q);
      back_value   <= (entry_count != '0) ? $signed(ram_rdata) : '0;
      occupancy    <= entry_count;
      is_empty     <= (entry_count == '0);
    end
  end

  `BDQ_ASSERT_SAME(a_count_in_range, clk, rst, 1'b1, entry_count <= CNT_W'(DEPTH))
  `BDQ_ASSERT_NEXT(a_push_grows, clk, rst, ctl.accept && push_ok, entry_count == $past(entry_count) + 1'b1)
  `BDQ_ASSERT_NEXT(a_pop_shrinks, clk, rst, ctl.accept && pop_ok, entry_count == $past(entry_count) - 1'b1)
  `BDQ_ASSERT_NEXT(a_refused_keeps, clk, rst, ctl.accept && !push_ok && !pop_ok, $stable(entry_count) && $stable(front_index) && $stable(back_index))

endmodule

[src/bounded_double_ended_queue.sv]
// A taken beat steps through S_POP, S_FRONT and S_BACK, one RAM read each, to the output.
// No beat is taken until the last result is loaded; S_HOLD waits while the output is busy.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst, synchronous): queue empty, pointers zero, capacity 16, output not valid.
// RAM contents are not cleared; data read from outside the two ends is never reported.
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]         occupancy,
  output logic                     is_empty,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [CAP_W-1:0] capacity;
  logic             reg_index;
  bdq_ctl_t         ctl;

  // Configuration port; the word index sits above the byte offset.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_index == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl)
  );

  bdq_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (cmd_t'(cmd)),
    .push_value  (push_value),
    .capacity    (capacity),
    .status      (status),
    .popped_value(popped_value),
    .front_value (front_value),
    .back_value  (back_value),
    .occupancy   (occupancy),
    .is_empty    (is_empty)
  );

endmodule

[bench/tb_bounded_double_ended_queue.sv]
// Self-checking testbench for the bounded double-ended queue: predicted results versus DUT beats.
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue
  import bdq_pkg::*;
();

  localparam int IDX_W = $clog2(DEPTH_DEFAULT);
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    cmd_t                     op;
    logic signed [DATA_W-1:0] value;
  } deque_op_t;

  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CAP_W-1:0]         count;
    logic                     empty;
  } deque_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] push_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CAP_W-1:0]         occupancy;
  logic                     is_empty;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // Pending operations for the driver and results still owed by the DUT.
  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];

  // Predicted queue contents, ends, count and capacity.
  logic signed [DATA_W-1:0] slots[DEPTH_DEFAULT];
  logic [IDX_W-1:0]         head_idx;
  logic [IDX_W-1:0]         tail_idx;
  logic [CAP_W-1:0]         held_count;
  logic [CAP_W-1:0]         model_capacity;

  int   error_count = 0;
  int   idle_pct;
  int   send_gap;
  int   stall_left;
  logic in_fire;

  bounded_double_ended_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .popped_value(popped_value),
    .front_value (front_value),
    .back_value  (back_value),
    .occupancy   (occupancy),
    .is_empty    (is_empty),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one operation to the predicted deque and returns the result it should produce.
  function automatic deque_result_t predict_deque_op(deque_op_t item);
    deque_result_t    r;
    logic [CAP_W-1:0] lim;
    logic [IDX_W-1:0] last_idx;
    r.st     = STAT_DONE;
    r.popped = '0;
    r.front  = '0;
    r.back   = '0;
    lim = (model_capacity > CAP_W'(DEPTH_DEFAULT)) ? CAP_W'(DEPTH_DEFAULT) : model_capacity;
    case (item.op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held_count >= lim) begin
          r.st = STAT_FULL;
        end else if (item.op == CMD_PUSH_FRONT) begin
          head_idx = head_idx - 1'b1;
          slots[head_idx] = item.value;
          held_count = held_count + 1'b1;
        end else begin
          slots[tail_idx] = item.value;
          tail_idx = tail_idx + 1'b1;
          held_count = held_count + 1'b1;
        end
      end
      default: begin
        if (held_count == '0) begin
          r.st = STAT_EMPTY;
        end else if (item.op == CMD_POP_FRONT) begin
          r.popped = slots[head_idx];
          head_idx = head_idx + 1'b1;
          held_count = held_count - 1'b1;
        end else begin
          tail_idx = tail_idx - 1'b1;
          r.popped = slots[tail_idx];
          held_count = held_count - 1'b1;
        end
      end
    endcase
    // Both ends are reported only while something is held.
    if (held_count != '0) begin
      last_idx = tail_idx - 1'b1;
      r.front = slots[head_idx];
      r.back  = slots[last_idx];
    end
    r.count = held_count;
    r.empty = (held_count == '0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic add_op(input cmd_t op, input logic signed [DATA_W-1:0] value);
    deque_op_t item;
    item.op    = op;
    item.value = value;
    pending_ops.insert(pending_ops.size(), item);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_capacity(input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_capacity = value[CAP_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every operation is sent and every result has come back.
  task automatic wait_drained;
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Runs of pushes and runs of pops fill and drain the deque, with a few stray commands.
  task automatic add_random_ops(input int n_ops);
    int  made;
    int  run;
    bit  pushing;
    logic signed [DATA_W-1:0] value;
    cmd_t op;
    made = 0;
    while (made < n_ops) begin
      pushing = $urandom_range(0, 1);
      run = $urandom_range(1, 24);
      for (int k = 0; k < run && made < n_ops; k++) begin
        case ($urandom_range(0, 9))
          0: value = MOST_NEG;
          1: value = MOST_POS;
          2: value = '0;
          3: value = -1;
          default: value = $urandom;
        endcase
        if ($urandom_range(0, 7) == 0) begin
          op = cmd_t'($urandom_range(0, 3));
        end else if (pushing) begin
          op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        add_op(op, value);
        made++;
      end
    end
  endtask

  // Input driver: holds a beat until it is taken, with random gaps between beats.
  always @(negedge clk) begin
    deque_op_t item;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_fire) begin
      // Beat still waiting for acceptance.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_ops.size() != 0 && idle_pct != 0 &&
                 $urandom_range(0, 99) < idle_pct) begin
      send_gap <= $urandom_range(0, 17);
      in_valid <= 1'b0;
    end else if (pending_ops.size() != 0) begin
      item = pending_ops[0];
      pending_ops.delete(0);
      cmd        <= item.op;
      push_value <= item.value;
      in_valid   <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side backpressure in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 17);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each result beat and predicts the result of each accepted beat.
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t predicted;
    deque_op_t     taken;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no operation outstanding");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("status", DATA_W'(status), DATA_W'(want.st));
          check_field("popped_value", popped_value, want.popped);
          check_field("front_value", front_value, want.front);
          check_field("back_value", back_value, want.back);
          check_field("occupancy", DATA_W'(occupancy), DATA_W'(want.count));
          check_field("is_empty", DATA_W'(is_empty), DATA_W'(want.empty));
        end
      end
      if (in_valid && in_ready) begin
        taken.op    = cmd_t'(cmd);
        taken.value = push_value;
        predicted   = predict_deque_op(taken);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst        = 1'b1;
    in_fire    = 1'b0;
    in_valid   = 1'b0;
    cmd        = '0;
    push_value = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_gap   = 0;
    stall_left = 0;
    idle_pct   = 20;
    for (int i = 0; i < DEPTH_DEFAULT; i++) slots[i] = '0;
    head_idx       = '0;
    tail_idx       = '0;
    held_count     = '0;
    model_capacity = CAP_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pops, extreme values, and pushes into a full deque.
    write_capacity(2);
    add_op(CMD_POP_FRONT, MOST_POS);
    add_op(CMD_POP_BACK, MOST_NEG);
    add_op(CMD_PUSH_FRONT, MOST_NEG);
    add_op(CMD_PUSH_BACK, MOST_POS);
    add_op(CMD_PUSH_FRONT, '0);
    add_op(CMD_PUSH_BACK, -1);
    add_op(CMD_POP_BACK, '0);
    add_op(CMD_POP_FRONT, -1);
    add_op(CMD_POP_FRONT, '0);
    wait_drained();

    // Zero capacity drops every push.
    write_capacity(0);
    add_op(CMD_PUSH_BACK, 32'sd123);
    add_op(CMD_PUSH_FRONT, -1);
    add_op(CMD_POP_BACK, '0);
    wait_drained();

    // Capacity lowered below the number of entries held.
    write_capacity(4);
    add_op(CMD_PUSH_BACK, 32'sd1);
    add_op(CMD_PUSH_BACK, 32'sd2);
    add_op(CMD_PUSH_BACK, 32'sd3);
    wait_drained();
    write_capacity(1);
    add_op(CMD_PUSH_FRONT, 32'sd4);
    add_op(CMD_POP_FRONT, '0);
    add_op(CMD_POP_FRONT, '0);
    add_op(CMD_PUSH_BACK, 32'sd5);
    add_op(CMD_POP_BACK, '0);
    add_op(CMD_PUSH_BACK, 32'sd6);
    wait_drained();

    // Random phases over several capacities, with varying amounts of idling.
    write_capacity(16);
    idle_pct = 20;
    add_random_ops(120);
    wait_drained();

    write_capacity(1);
    idle_pct = 40;
    add_random_ops(60);
    wait_drained();

    write_capacity(31);
    idle_pct = 10;
    add_random_ops(150);
    wait_drained();

    write_capacity(0);
    idle_pct = 20;
    add_random_ops(30);
    wait_drained();

    write_capacity($urandom_range(2, 15));
    idle_pct = 30;
    add_random_ops(130);
    wait_drained();

    write_capacity($urandom_range(17, 30));
    idle_pct = 0;
    add_random_ops(130);
    wait_drained();

    // Closing stretch at full rate on both sides.
    write_capacity(16);
    idle_pct = 0;
    add_random_ops(130);
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
